/* rtl/dsp_host_bus_window_top_assert.svh */
// dsp_host_bus_window_top_assert.svh: assertion macros for the bus window RTL.
// Included by modules that carry concurrent assertions; no other dependency.
`ifndef DSP_HOST_BUS_WINDOW_TOP_ASSERT_SVH
`define DSP_HOST_BUS_WINDOW_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HBW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bus window assertion failed");

// Next-cycle implication, disabled during reset.
`define HBW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bus window assertion failed");

`endif

/* rtl/dsp_hbw_pkg.sv */
// dsp_hbw_pkg.sv: types, address constants and decode helpers of the bus window.
// No dependencies.
package dsp_hbw_pkg;

    localparam int ADDR_W = 24;
    localparam int DATA_W = 16;
    localparam int IDX_W  = 16;

    localparam int QPTR_W  = 1;
    localparam int Q_DEPTH = 1 << QPTR_W;

    localparam logic [ADDR_W-1:0] WIN_MASK   = 24'hfe0000;
    localparam logic [ADDR_W-1:0] WIN_BASE   = 24'h300000;
    localparam logic [ADDR_W-1:0] BANK_MASK  = 24'hff0000;
    localparam logic [ADDR_W-1:0] VIEW1_BASE = 24'h390000;
    localparam logic [ADDR_W-1:0] VIEW2_BASE = 24'h3a0000;
    localparam logic [ADDR_W-1:0] MBX_MASK   = 24'hfffff0;
    localparam logic [ADDR_W-1:0] MBX_BASE   = 24'ha15000;
    localparam logic [ADDR_W-1:0] MBX_XCHG1  = 24'ha15002;
    localparam logic [ADDR_W-1:0] WAKE06_ADR = 24'h30fe06;
    localparam logic [ADDR_W-1:0] WAKE08_ADR = 24'h30fe08;

    localparam logic [3:0] MBX_SEL_XCHG0 = 4'h0;
    localparam logic [3:0] MBX_SEL_XCHG1 = 4'h2;
    localparam logic [3:0] MBX_SEL_STAT  = 4'h4;

    localparam logic [22:0] VIEW1_KEEP = 23'h7001;
    localparam logic [22:0] VIEW2_KEEP = 23'h7801;

    typedef enum logic [1:0] {
        ACT_READ    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_STAT_LD = 2'd2,
        ACT_RSVD    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DRAM_RD,
        OP_DRAM_WR,
        OP_XCHG_RD,
        OP_STAT_RD,
        OP_XCHG_WR,
        OP_STAT_LD
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        logic              wake06;
        logic              wake08;
        logic              unh;
    } t_cmd;

    // Cell arrange view one, w = byte address >> 1.
    function automatic logic [IDX_W-1:0] view1_idx(input logic [22:0] w);
        logic [22:0] r;
        r = (w & VIEW1_KEEP) | ((w & 23'h3e) << 6) | ((w & 23'hfc0) >> 5);
        return r[IDX_W-1:0];
    endfunction

    // Cell arrange view two.
    function automatic logic [IDX_W-1:0] view2_idx(input logic [22:0] w);
        logic [22:0] r;
        r = (w & VIEW2_KEEP) | ((w & 23'h1e) << 6) | ((w & 23'h7e0) >> 4);
        return r[IDX_W-1:0];
    endfunction

endpackage

/* rtl/dsp_hbw_if.sv */
// dsp_hbw_if.sv: valid/ready channel interfaces for bus accesses and results.
// Depends on dsp_hbw_pkg.
interface dsp_hbw_in_if import dsp_hbw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, action, address, write_data, input ready);
    modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface dsp_hbw_out_if import dsp_hbw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              status_wake;
    logic              wake_fe06;
    logic              wake_fe08;
    logic              unhandled;

    modport source (output valid, read_data, status_wake, wake_fe06, wake_fe08, unhandled,
                    input ready);
    modport sink   (input valid, read_data, status_wake, wake_fe06, wake_fe08, unhandled,
                    output ready);
endinterface

/* rtl/dsp_hbw_front.sv */
// dsp_hbw_front.sv: accepts host accesses and decodes them into commands.
// Depends on dsp_hbw_pkg and dsp_hbw_if.
module dsp_hbw_front import dsp_hbw_pkg::*; #(
    parameter int DRAM_WORDS = 65536
) (
    dsp_hbw_in_if.sink i_in,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [IDX_W:0] WORDS = (IDX_W+1)'(DRAM_WORDS);

    logic [22:0]      w;
    logic [IDX_W-1:0] raw_idx;
    logic [IDX_W:0]   ext_idx;
    logic             in_win, in_v1, in_v2, in_mbx;

    assign w       = i_in.address[ADDR_W-1:1];
    assign in_win  = (i_in.address & WIN_MASK)  == WIN_BASE;
    assign in_v1   = (i_in.address & BANK_MASK) == VIEW1_BASE;
    assign in_v2   = (i_in.address & BANK_MASK) == VIEW2_BASE;
    assign in_mbx  = (i_in.address & MBX_MASK)  == MBX_BASE;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        if (in_win) begin
            raw_idx = i_in.address[16:1];
        end else if (in_v1) begin
            raw_idx = view1_idx(w);
        end else begin
            raw_idx = view2_idx(w);
        end
    end

    // one compare and subtract wraps an index that stays below twice the depth
    assign ext_idx = {1'b0, raw_idx};

    always_comb begin
        o_cmd.op     = OP_NONE;
        o_cmd.idx    = (ext_idx >= WORDS) ? IDX_W'(ext_idx - WORDS) : raw_idx;
        o_cmd.data   = i_in.write_data;
        o_cmd.wake06 = 1'b0;
        o_cmd.wake08 = 1'b0;
        o_cmd.unh    = 1'b0;
        case (t_action'(i_in.action))
            ACT_READ: begin
                if (in_win || in_v1 || in_v2) begin
                    o_cmd.op = OP_DRAM_RD;
                end else if (in_mbx) begin
                    if (i_in.address[3:0] == MBX_SEL_XCHG0 ||
                        i_in.address[3:0] == MBX_SEL_XCHG1) begin
                        o_cmd.op = OP_XCHG_RD;
                    end else if (i_in.address[3:0] == MBX_SEL_STAT) begin
                        o_cmd.op = OP_STAT_RD;
                    end
                end else begin
                    o_cmd.unh = 1'b1;
                end
            end
            ACT_WRITE: begin
                if (in_win) begin
                    o_cmd.op = OP_DRAM_WR;
                end else if (in_mbx) begin
                    if (i_in.address == MBX_BASE || i_in.address == MBX_XCHG1) begin
                        o_cmd.op = OP_XCHG_WR;
                    end
                end else begin
                    o_cmd.unh = 1'b1;
                end
                o_cmd.wake06 = (i_in.address == WAKE06_ADR) && (i_in.write_data != '0);
                o_cmd.wake08 = (i_in.address == WAKE08_ADR) && (i_in.write_data != '0);
            end
            ACT_STAT_LD: begin
                o_cmd.op = OP_STAT_LD;
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

/* rtl/dsp_hbw_fifo.sv */
// dsp_hbw_fifo.sv: short command queue between decode and execute.
// Depends on dsp_hbw_pkg and the assertion macro header.
`include "dsp_host_bus_window_top_assert.svh"

module dsp_hbw_fifo import dsp_hbw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt, n_cnt;

    assign o_full  = r_cnt == (QPTR_W+1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    `HBW_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (QPTR_W+1)'(Q_DEPTH))
    `HBW_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `HBW_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)

endmodule

/* rtl/dsp_hbw_back.sv */
// dsp_hbw_back.sv: executes commands against the shared DRAM and the mailbox.
// Depends on dsp_hbw_pkg, dsp_hbw_if and the assertion macro header.
`include "dsp_host_bus_window_top_assert.svh"

module dsp_hbw_back import dsp_hbw_pkg::*; #(
    parameter int DRAM_WORDS = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    dsp_hbw_out_if.source o_out
);

    localparam int AW = $clog2(DRAM_WORDS);

    logic [DATA_W-1:0] r_dram [DRAM_WORDS];
    logic [DATA_W-1:0] r_dram_q;
    logic [DATA_W-1:0] r_xchg, r_status;
    logic              r_s1_valid;
    t_op               r_s1_op;
    logic [DATA_W-1:0] r_s1_rd;
    logic              r_s1_w06, r_s1_w08, r_s1_unh;
    logic [AW-1:0]     addr;

    assign addr  = i_cmd.idx[AW-1:0];
    assign o_pop = i_q_valid && (!r_s1_valid || o_out.ready);

    // single-port DRAM, registered read
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_cmd.op == OP_DRAM_WR) begin
                r_dram[addr] <= i_cmd.data;
            end
            r_dram_q <= r_dram[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_xchg     <= '0;
            r_status   <= '0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_s1_valid <= 1'b0;
            end
            if (o_pop) begin
                case (i_cmd.op)
                    OP_STAT_RD: r_status <= r_status & ~DATA_W'(1);
                    OP_XCHG_WR: begin
                        r_xchg   <= i_cmd.data;
                        r_status <= r_status | DATA_W'(2);
                    end
                    OP_STAT_LD: r_status <= i_cmd.data;
                    default:    r_status <= r_status;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_op  <= i_cmd.op;
            r_s1_w06 <= i_cmd.wake06;
            r_s1_w08 <= i_cmd.wake08;
            r_s1_unh <= i_cmd.unh;
            case (i_cmd.op)
                OP_XCHG_RD: r_s1_rd <= r_xchg;
                OP_STAT_RD: r_s1_rd <= r_status;
                default:    r_s1_rd <= '0;
            endcase
        end
    end

    assign o_out.valid       = r_s1_valid;
    assign o_out.read_data   = (r_s1_op == OP_DRAM_RD) ? r_dram_q : r_s1_rd;
    assign o_out.status_wake = r_s1_op == OP_XCHG_WR;
    assign o_out.wake_fe06   = r_s1_w06;
    assign o_out.wake_fe08   = r_s1_w08;
    assign o_out.unhandled   = r_s1_unh;

    `HBW_ASSERT_NEXT(a_xchg_sets_flag, i_clk, i_rst_n, o_pop && i_cmd.op == OP_XCHG_WR, r_status[1])
    `HBW_ASSERT_NOW(a_unh_quiet, i_clk, i_rst_n, r_s1_valid && r_s1_unh, o_out.read_data == '0 && !o_out.status_wake)

endmodule

/* rtl/dsp_host_bus_window_top.sv */
// dsp_host_bus_window_top.sv: host bus window of the DSP coprocessor, top level.
// Depends on dsp_hbw_pkg, dsp_hbw_if, dsp_hbw_front, dsp_hbw_fifo and dsp_hbw_back.
//
// Host-side 16-bit bus window. Each input word is one host read or write at a
// 24-bit byte address, or a status register load from the DSP side; each gives
// exactly one result word. 0x300000-0x31ffff maps the shared word DRAM,
// 0x39xxxx and 0x3axxxx are read-only bit-permuted views of it, 0xa15000 holds
// the mailbox (exchange register at +0/+2, status at +4, cleared bit 0 on read),
// and nonzero writes to 0x30fe06/0x30fe08 raise their wake bits. Other accesses
// report unhandled with zero data; unused mailbox offsets give zero data, no
// flag. Timing: the decoder takes a word whenever the two-entry command queue
// has room; the executor pops one command per cycle, while its output register
// is empty or being taken, into that register, so a result passes through the
// queue and then the output register. The block sustains one word per cycle
// while the output is taken. That figure is set by the single DRAM port, which
// serves one read or one write per cycle. With the output held off, the queue
// and the output register hold three words before the input stalls. The DRAM
// contents are undefined after reset and are not cleared; reset only clears the
// mailbox registers and the pipeline control, so the block is ready at once.
module dsp_host_bus_window_top import dsp_hbw_pkg::*; #(
    parameter int DRAM_WORDS = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dsp_hbw_in_if.sink    i_in,
    dsp_hbw_out_if.source o_out
);

    t_cmd front_cmd, q_cmd;
    logic front_push;
    logic q_full, q_valid, q_pop;

    // decode: address regions, access kind, wake conditions
    dsp_hbw_front #(
        .DRAM_WORDS (DRAM_WORDS)
    ) u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (front_push),
        .o_cmd    (front_cmd)
    );

    // decouples decode from execute so either side can stall
    dsp_hbw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    // execute: DRAM access, mailbox side effects, result register
    dsp_hbw_back #(
        .DRAM_WORDS (DRAM_WORDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
